// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and step functions for the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned QW          = 16;  // Q1.14 field width
  localparam int unsigned DW          = 17;  // off-diagonal pair width
  localparam int unsigned RAD_W       = 31;  // root argument in Q28
  localparam int unsigned RES_W       = 32;  // square root working register
  localparam int unsigned ROOT_W      = 16;  // final root
  localparam int unsigned NUM_W       = 30;  // dividend width
  localparam int unsigned SQRT_STEPS  = 16;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned SQRT_STAGES = SQRT_STEPS / STEPS_PER_STAGE;
  localparam int unsigned DIV_STAGES  = DIV_STEPS / STEPS_PER_STAGE;
  localparam int unsigned SETUP_STAGE = 1 + SQRT_STAGES;
  localparam int unsigned NUM_STAGES  = 2 + SQRT_STAGES + DIV_STAGES;

  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef struct packed {
    logic [1:0]                 which;
    logic [3:0][DW-1:0]         d;
    logic [RAD_W-1:0]           rad;
    logic [RES_W-1:0]           res;
    logic [ROOT_W-1:0]          root;
    logic [QW-1:0]              chosen;
    logic [3:0][NUM_W-1:0]      rem;
    logic [3:0][QW-1:0]         quo;
    logic [3:0]                 ovf;
  } stage_t;

  // One digit pair of the bitwise square root.
  function automatic stage_t sqrt_step(stage_t s, int unsigned i);
    stage_t          r;
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    r     = s;
    bitv  = RES_W'(1) << (2 * i);
    trial = r.res + bitv;
    if ({1'b0, r.rad} >= trial) begin
      r.rad = r.rad - trial[RAD_W-1:0];
      r.res = (r.res >> 1) + bitv;
    end else begin
      r.res = r.res >> 1;
    end
    return r;
  endfunction

  // Forms the rounded dividends and the overflow flags once the root is known.
  function automatic stage_t div_setup(stage_t s);
    stage_t          r;
    logic [DW-1:0]   mag;
    logic [ROOT_W:0] rp1;
    r      = s;
    r.root = s.res[ROOT_W-1:0];
    rp1    = {1'b0, r.root} + (ROOT_W+1)'(1);
    r.chosen = rp1[ROOT_W:1];
    for (int k = 0; k < 4; k++) begin
      mag = s.d[k][DW-1] ? (~s.d[k] + DW'(1)) : s.d[k];
      r.rem[k] = {mag, 13'b0} + NUM_W'(r.root >> 1);
      r.ovf[k] = {2'b0, r.rem[k]} >= {r.root, 16'b0};
      r.quo[k] = '0;
    end
    return r;
  endfunction

  // One restoring division step on all four lanes.
  function automatic stage_t div_step(stage_t s, int unsigned j);
    stage_t      r;
    logic [31:0] dv;
    r  = s;
    dv = {16'b0, s.root} << j;
    for (int k = 0; k < 4; k++) begin
      if ({2'b0, r.rem[k]} >= dv) begin
        r.rem[k]    = r.rem[k] - dv[NUM_W-1:0];
        r.quo[k][j] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_mat_if / rmq_quat_if
// Valid/ready channels for the matrix requests and the quaternion results.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] row0_col0;
  logic signed [15:0] row0_col1;
  logic signed [15:0] row0_col2;
  logic signed [15:0] row1_col0;
  logic signed [15:0] row1_col1;
  logic signed [15:0] row1_col2;
  logic signed [15:0] row2_col0;
  logic signed [15:0] row2_col1;
  logic signed [15:0] row2_col2;

  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, input ready);
  modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                row1_col2, row2_col0, row2_col1, row2_col2, output ready);
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, root argument and off-diagonal pair values.
// ----------------------------------------------------------------------------
module rmq_front
  import rmq_pkg::*;
(
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m20_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  output stage_t             stage_o
);

  logic signed [17:0] a00, a11, a22, trace, arg;
  logic signed [16:0] add01, add02, add12, sub21, sub02, sub10;
  logic [16:0]        arg_c;

  assign a00   = 18'(m00_i);
  assign a11   = 18'(m11_i);
  assign a22   = 18'(m22_i);
  assign trace = a00 + a11 + a22;

  assign add01 = 17'(m01_i) + 17'(m10_i);
  assign add02 = 17'(m02_i) + 17'(m20_i);
  assign add12 = 17'(m12_i) + 17'(m21_i);
  assign sub21 = 17'(m21_i) - 17'(m12_i);
  assign sub02 = 17'(m02_i) - 17'(m20_i);
  assign sub10 = 17'(m10_i) - 17'(m01_i);

  always_comb begin
    stage_o = '0;
    if (trace > 0) begin
      stage_o.which = SEL_W;
      arg = 18'sd16384 + trace;
      stage_o.d[1] = sub21;
      stage_o.d[2] = sub02;
      stage_o.d[3] = sub10;
    end else if (m00_i > m11_i && m00_i > m22_i) begin
      stage_o.which = SEL_X;
      arg = 18'sd16384 + a00 - a11 - a22;
      stage_o.d[0] = sub21;
      stage_o.d[2] = add01;
      stage_o.d[3] = add02;
    end else if (m11_i > m22_i) begin
      stage_o.which = SEL_Y;
      arg = 18'sd16384 + a11 - a00 - a22;
      stage_o.d[0] = sub02;
      stage_o.d[1] = add01;
      stage_o.d[3] = add12;
    end else begin
      stage_o.which = SEL_Z;
      arg = 18'sd16384 + a22 - a00 - a11;
      stage_o.d[0] = sub10;
      stage_o.d[1] = add02;
      stage_o.d[2] = add12;
    end
    // A matrix that is not a rotation can drive the argument to zero or below.
    arg_c = (arg <= 0) ? 17'd1 : arg[16:0];
    stage_o.rad = {arg_c, 14'b0};
  end

endmodule

// File: rtl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a Q1.14 rotation matrix into a Q1.14 quaternion (Shepperd).
// ----------------------------------------------------------------------------
// Usage: a 3x3 matrix enters on in_i as a valid/ready request; the quaternion
// leaves on out_o. A request is taken at each clock edge with valid and ready
// high. The pipeline has 18 register stages: one for branch selection, eight
// for the square root (two result bits per stage), one to form the rounded
// dividends, and eight for the three divisions by twice the root (two
// quotient bits per stage, all lanes in parallel). A request passes the
// stages in that order and out_o.valid rises once its result is in the
// last stage; one request is taken every cycle while the output is
// drained. When the receiver holds ready low, the pipeline stalls
// but empty stages still fill, so up to 18 requests are held and in_i.ready
// drops only when all stages are occupied. Reset empties every stage; the
// payload registers are not cleared.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rmq_mat_if.sink    in_i,
  rmq_quat_if.source out_o
);

  stage_t                  st_d [NUM_STAGES];
  stage_t                  st_q [NUM_STAGES];
  logic [NUM_STAGES-1:0]   v_q;
  logic [NUM_STAGES:0]     en;
  stage_t                  front;
  stage_t                  last;

  rmq_front u_front (
    .m00_i   (in_i.row0_col0),
    .m01_i   (in_i.row0_col1),
    .m02_i   (in_i.row0_col2),
    .m10_i   (in_i.row1_col0),
    .m11_i   (in_i.row1_col1),
    .m12_i   (in_i.row1_col2),
    .m20_i   (in_i.row2_col0),
    .m21_i   (in_i.row2_col1),
    .m22_i   (in_i.row2_col2),
    .stage_o (front)
  );

  assign en[NUM_STAGES] = out_o.ready;
  assign in_i.ready     = en[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    // A stage moves when it is empty or its successor moves.
    assign en[s] = !v_q[s] || en[s+1];

    if (s == 0) begin : g_front
      assign st_d[s] = front;
    end else if (s < SETUP_STAGE) begin : g_sqrt
      localparam int unsigned IHI = SQRT_STEPS - STEPS_PER_STAGE * (s - 1) - 1;
      assign st_d[s] = sqrt_step(sqrt_step(st_q[s-1], IHI), IHI - 1);
    end else if (s == SETUP_STAGE) begin : g_setup
      assign st_d[s] = div_setup(st_q[s-1]);
    end else begin : g_div
      localparam int unsigned JHI = DIV_STEPS - STEPS_PER_STAGE * (s - SETUP_STAGE - 1) - 1;
      assign st_d[s] = div_step(div_step(st_q[s-1], JHI), JHI - 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= (s == 0) ? in_i.valid : v_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign last = st_q[NUM_STAGES-1];

  function automatic logic [QW-1:0] sat_q(logic [QW-1:0] quo, logic ovf, logic neg);
    logic [QW-1:0] r;
    if (neg) begin
      r = (ovf || quo > 16'd32768) ? 16'h8000 : (~quo + 16'd1);
    end else begin
      r = (ovf || quo[QW-1]) ? 16'h7fff : quo;
    end
    return r;
  endfunction

  logic [3:0][QW-1:0] comp;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (last.which == 2'(k)) begin
        comp[k] = last.chosen;
      end else begin
        comp[k] = sat_q(last.quo[k], last.ovf[k], last.d[k][DW-1]);
      end
    end
  end

  assign out_o.valid  = v_q[NUM_STAGES-1];
  assign out_o.quat_w = comp[0];
  assign out_o.quat_x = comp[1];
  assign out_o.quat_y = comp[2];
  assign out_o.quat_z = comp[3];

endmodule
